@@ sv/nnsr_pkg.sv @@
package nnsr_pkg;

  localparam int FRAME_CAPACITY = 64;
  localparam int CNT_W          = 7;
  localparam int SAMPLE_W       = 16;
  localparam int JOB_DEPTH      = 2;

  typedef logic [CNT_W-1:0] cnt_t;

  // one closed block, waiting for or under emission
  typedef struct packed {
    cnt_t n;
    cnt_t m;
    logic bank;
  } job_t;

  typedef struct packed {
    logic                en;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } frame_wr_t;

endpackage

@@ sv/nnsr_front.sv @@
module nnsr_front #(
  parameter int CAP = nnsr_pkg::FRAME_CAPACITY,
  parameter int AW  = $clog2(CAP)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [nnsr_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [nnsr_pkg::SAMPLE_W-1:0] right_in,
  input  logic                             last_input,
  input  logic [nnsr_pkg::CNT_W-1:0]       out_frames,
  input  logic                             job_full,
  output logic                             job_push,
  output nnsr_pkg::job_t                   job,
  output nnsr_pkg::frame_wr_t              wr,
  output logic [AW:0]                      wr_addr
);

  localparam nnsr_pkg::cnt_t CAP_C = nnsr_pkg::CNT_W'(CAP);

  nnsr_pkg::cnt_t loaded;
  logic           wbank;
  logic           take;
  logic           has_room;

  assign in_stall = job_full;
  assign take     = in_valid && !job_full;
  assign has_room = loaded < CAP_C;

  assign wr.en    = take && has_room;
  assign wr.left  = left_in;
  assign wr.right = right_in;
  assign wr_addr  = {wbank, loaded[AW-1:0]};

  assign job_push = take && last_input;
  assign job.n    = has_room ? loaded + 1'b1 : CAP_C;
  assign job.m    = (out_frames > CAP_C) ? CAP_C : out_frames;
  assign job.bank = wbank;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      wbank  <= 1'b0;
    end else if (take) begin
      if (last_input) begin
        loaded <= '0;
        wbank  <= !wbank;
      end else if (has_room) begin
        loaded <= loaded + 1'b1;
      end
    end
  end

endmodule

@@ sv/nnsr_job_fifo.sv @@
module nnsr_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nnsr_pkg::job_t push_job,
  input  logic           pop,
  output nnsr_pkg::job_t head,
  output logic           empty,
  output logic           full
);

  nnsr_pkg::job_t entry [nnsr_pkg::JOB_DEPTH];
  logic           wp;
  logic           rp;
  logic [1:0]     count;

  assign head  = entry[rp];
  assign empty = count == 2'd0;
  assign full  = count == 2'(nnsr_pkg::JOB_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/nnsr_back.sv @@
module nnsr_back #(
  parameter int CAP = nnsr_pkg::FRAME_CAPACITY,
  parameter int AW  = $clog2(CAP)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  nnsr_pkg::frame_wr_t              wr,
  input  logic [AW:0]                      wr_addr,
  input  nnsr_pkg::job_t                   head,
  input  logic                             job_empty,
  output logic                             job_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [nnsr_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [nnsr_pkg::SAMPLE_W-1:0] right_out,
  output logic                             last_output
);

  localparam int DW = nnsr_pkg::CNT_W + 1;
  localparam int SW = 2 * nnsr_pkg::SAMPLE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  logic [SW-1:0] mem [2**(AW+1)];
  logic [SW-1:0] mem_q;

  nnsr_pkg::cnt_t n;
  nnsr_pkg::cnt_t m;
  nnsr_pkg::cnt_t i;
  logic           bank;
  logic [DW-1:0]  den;
  logic [DW-1:0]  dvd;
  logic [DW-1:0]  rem;
  logic [2:0]     dcnt;
  logic [DW-1:0]  sq;
  logic [DW-1:0]  sr;
  logic [DW-1:0]  q;
  logic [DW-1:0]  r;

  logic [DW-1:0]  rem_sh;
  logic           rem_ge;
  logic [DW-1:0]  r_sum;
  logic [DW-1:0]  src;
  logic           is_last;
  logic           out_take;
  logic           issue;
  logic           rd_pend;
  logic           rd_last;
  logic [AW:0]    rd_addr;

  assign rem_sh   = {rem[DW-2:0], dvd[DW-1]};
  assign rem_ge   = rem_sh >= den;
  assign r_sum    = r + sr;
  assign src      = (q >= DW'(n)) ? DW'(n - 1'b1) : q;
  assign is_last  = i == m - 1'b1;
  assign out_take = out_valid && !out_stall;
  assign issue    = (state == ST_EMIT) && !rd_pend && (!out_valid || out_take);
  assign rd_addr  = {bank, src[AW-1:0]};
  assign job_pop  = ((state == ST_IDLE) && !job_empty && (head.m == '0))
                  || (issue && is_last);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= {wr.right, wr.left};
    end
    if (issue) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!job_empty && head.m != '0) begin
            n    <= head.n;
            m    <= head.m;
            bank <= head.bank;
            i    <= '0;
            if (head.m == nnsr_pkg::CNT_W'(1)) begin
              q     <= DW'(head.n >> 1);
              r     <= '0;
              sq    <= '0;
              sr    <= '0;
              den   <= '0;
              state <= ST_EMIT;
            end else begin
              dvd   <= {head.n - 1'b1, 1'b0};
              den   <= {head.m - 1'b1, 1'b0};
              rem   <= '0;
              dcnt  <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem  <= rem_ge ? rem_sh - den : rem_sh;
          dvd  <= {dvd[DW-2:0], rem_ge};
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'(DW - 1)) begin
            sq    <= {dvd[DW-2:0], rem_ge};
            sr    <= rem_ge ? rem_sh - den : rem_sh;
            q     <= '0;
            r     <= DW'(m - 1'b1);
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            i <= i + 1'b1;
            if (r_sum >= den) begin
              r <= r_sum - den;
              q <= q + sq + 1'b1;
            end else begin
              r <= r_sum;
              q <= q + sq;
            end
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (rd_pend) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last <= is_last;
    end
    if (rd_pend) begin
      left_out    <= mem_q[nnsr_pkg::SAMPLE_W-1:0];
      right_out   <= mem_q[SW-1:nnsr_pkg::SAMPLE_W];
      last_output <= rd_last;
    end
  end

endmodule

@@ sv/nearest_neighbor_stereo_resampler.sv @@
// Nearest-neighbour stereo block resampler.
// Input channel (in_valid/in_stall): one stereo frame per word. A word with
// last_input set closes the block and carries out_frames, the number of
// output words wanted (clamped to CAP; zero emits nothing). Frames beyond
// CAP in one block are dropped, though their last mark still closes it.
// Output channel (out_valid/out_stall): out_frames words of picked source
// frames, last_output set on the final one.
// Frames load one per cycle, while in_stall is low, into one of two store
// banks. A closed block waits in a two-entry job queue; the emitter runs a
// bit-serial divide for the step size (skipped when one frame is wanted) and
// then issues each word through the registered store read, the next only
// once that read is done and the output register is free or being taken.
// in_stall rises only while both banks hold blocks not yet fully emitted.
// A stalled output holds its word; the emitter waits, loading goes on.
// Synchronous reset empties the queue, the block counter and the output.
module nearest_neighbor_stereo_resampler #(
  parameter int CAP = nnsr_pkg::FRAME_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [nnsr_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [nnsr_pkg::SAMPLE_W-1:0] right_in,
  input  logic                                 last_input,
  input  logic [nnsr_pkg::CNT_W-1:0]           out_frames,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [nnsr_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [nnsr_pkg::SAMPLE_W-1:0] right_out,
  output logic                                 last_output
);

  localparam int AW = $clog2(CAP);

  nnsr_pkg::job_t      push_job;
  nnsr_pkg::job_t      head;
  nnsr_pkg::frame_wr_t wr;
  logic [AW:0]         wr_addr;
  logic                job_push;
  logic                job_pop;
  logic                job_full;
  logic                job_empty;

  nnsr_front #(.CAP(CAP), .AW(AW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_in    (left_in),
    .right_in   (right_in),
    .last_input (last_input),
    .out_frames (out_frames),
    .job_full   (job_full),
    .job_push   (job_push),
    .job        (push_job),
    .wr         (wr),
    .wr_addr    (wr_addr)
  );

  nnsr_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head     (head),
    .empty    (job_empty),
    .full     (job_full)
  );

  nnsr_back #(.CAP(CAP), .AW(AW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .head        (head),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_out    (left_out),
    .right_out   (right_out),
    .last_output (last_output)
  );

endmodule
